>>> hw/rtl/dss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal seven-segment scan: shared types, constants and functions
// Widths of the number and digit fields, the conversion pipeline split and
// the common-anode segment table.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int NUMBER_W        = 24;
  localparam int MAX_DIGITS      = 7;
  localparam int DIGIT_W         = 4;
  // A 24-bit number has at most eight decimal digits.
  localparam int BCD_DIGITS      = 8;
  localparam int BCD_W           = BCD_DIGITS * DIGIT_W;
  localparam int POS_W           = 3;
  localparam int SEG_W           = 8;
  localparam int STEPS_PER_STAGE = 6;
  localparam int N_STAGES        = NUMBER_W / STEPS_PER_STAGE;
  localparam int OUT_DATA_W      = 24;

  typedef struct packed {
    logic [BCD_W-1:0]    bcd;
    logic [NUMBER_W-1:0] bin;
  } conv_t;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [DIGIT_W-1:0] digit_value;
    logic [SEG_W-1:0]   segments;
    logic [SEG_W-1:0]   digit_select;
    logic               last;
  } result_t;

  // One shift-and-add-three step of the binary to decimal conversion.
  function automatic conv_t dabble_step(conv_t c);
    conv_t r;
    r = c;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (r.bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        r.bcd[d*DIGIT_W +: DIGIT_W] = r.bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end
    end
    r = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
    return r;
  endfunction

  function automatic logic [SEG_W-1:0] seg_lookup(logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'h0:    s = 8'hC0;
      4'h1:    s = 8'hF9;
      4'h2:    s = 8'hA4;
      4'h3:    s = 8'hB0;
      4'h4:    s = 8'h99;
      4'h5:    s = 8'h92;
      4'h6:    s = 8'h82;
      4'h7:    s = 8'hF8;
      4'h8:    s = 8'h80;
      4'h9:    s = 8'h90;
      4'hA:    s = 8'h88;
      4'hB:    s = 8'h83;
      4'hC:    s = 8'hC6;
      4'hD:    s = 8'hA1;
      4'hE:    s = 8'h86;
      default: s = 8'h8E;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/dss_bcd_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal seven-segment scan: conversion stage
// Registered stage that applies a fixed number of shift-and-add-three steps,
// with a valid bit and back-pressure.
// ----------------------------------------------------------------------------
module dss_bcd_stage
  import dss_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire conv_t in_data_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output conv_t      out_data_o
);

  logic  valid_q;
  conv_t data_q, data_d;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    data_d = in_data_i;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      data_d = dabble_step(data_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/dss_digit_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal seven-segment scan: digit emitter
// Holds one converted number and issues its digits, least significant first,
// into an output register, one beat per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module dss_digit_emit
  import dss_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [BCD_W-1:0] in_bcd_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output result_t               out_data_o
);

  logic               busy_q;
  logic [POS_W-1:0]   pos_q;
  logic [POS_W-1:0]   last_q, last_d;
  logic [DIGIT_W-1:0] digits_q [MAX_DIGITS];
  logic               out_valid_q;
  result_t            out_q;
  logic               out_load;
  logic               final_digit;
  logic [DIGIT_W-1:0] cur_digit;

  assign cur_digit   = digits_q[pos_q];
  assign final_digit = (pos_q == last_q);
  assign out_load    = busy_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !busy_q || (out_load && final_digit);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A nonzero digit beyond the shown ones makes the top shown digit the last.
  always_comb begin
    last_d = '0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (in_bcd_i[i*DIGIT_W +: DIGIT_W] != '0) begin
        last_d = (i < MAX_DIGITS) ? POS_W'(i) : POS_W'(MAX_DIGITS - 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        busy_q <= 1'b1;
        pos_q  <= '0;
      end else if (out_load && final_digit) begin
        busy_q <= 1'b0;
      end else if (out_load) begin
        pos_q <= pos_q + POS_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      last_q <= last_d;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digits_q[i] <= in_bcd_i[i*DIGIT_W +: DIGIT_W];
      end
    end
    if (out_load) begin
      out_q.position     <= pos_q;
      out_q.digit_value  <= cur_digit;
      out_q.segments     <= seg_lookup(cur_digit);
      out_q.digit_select <= SEG_W'(8'h80) >> pos_q;
      out_q.last         <= final_digit;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/decimal_seven_segment_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal seven-segment scan driver
// Converts a 24-bit unsigned number to decimal and streams one beat per digit.
// ----------------------------------------------------------------------------
// Each input beat carries a number; the block returns its decimal digits least
// significant first, one output beat per digit, up to seven digits, with tlast
// on the most significant nonzero digit, or on the seventh when the number has
// eight digits (zero gives a single digit). The digit emitter sends one beat
// per cycle while the output is not stalled; a new number may enter every
// cycle into the four-stage conversion pipeline while it is not backed up, so
// later numbers are converted while earlier ones are still being emitted.
// ----------------------------------------------------------------------------
module decimal_seven_segment_scan
  import dss_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [NUMBER_W-1:0]   s_axis_tdata,   // [23:0] number
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [2:0] position, [6:3] digit_value,
                                                     // [14:7] segments,
                                                     // [22:15] digit_select, [23] zero
  output logic                       m_axis_tlast    // last
);

  logic    st_valid [N_STAGES+1];
  logic    st_ready [N_STAGES+1];
  conv_t   st_data  [N_STAGES+1];
  result_t res;

  assign st_valid[0]    = s_axis_tvalid;
  assign s_axis_tready  = st_ready[0];
  assign st_data[0].bcd = '0;
  assign st_data[0].bin = s_axis_tdata;

  for (genvar g = 0; g < N_STAGES; g++) begin : g_stage
    dss_bcd_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (st_valid[g]),
      .in_ready_o  (st_ready[g]),
      .in_data_i   (st_data[g]),
      .out_valid_o (st_valid[g+1]),
      .out_ready_i (st_ready[g+1]),
      .out_data_o  (st_data[g+1])
    );
  end

  dss_digit_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (st_valid[N_STAGES]),
    .in_ready_o  (st_ready[N_STAGES]),
    .in_bcd_i    (st_data[N_STAGES].bcd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = {1'b0, res.digit_select, res.segments, res.digit_value, res.position};
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

>>> verif/dss_scan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal seven-segment scan checker
// Watches both stream channels of the scan driver. Every accepted number is
// expanded into its expected digit beats. Every output beat is compared field
// by field with the oldest of them. Failures and the count of outstanding
// digit beats are handed to the testbench top.
// ----------------------------------------------------------------------------
module dss_scan_checker
  import dss_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  input  wire logic                  s_axis_tready_i,
  input  wire logic [NUMBER_W-1:0]   s_axis_tdata_i,   // [23:0] number
  input  wire logic                  m_axis_tvalid_i,
  input  wire logic                  m_axis_tready_i,
  input  wire logic [OUT_DATA_W-1:0] m_axis_tdata_i,   // [2:0] position, [6:3] digit_value,
                                                       // [14:7] segments,
                                                       // [22:15] digit_select, [23] zero
  input  wire logic                  m_axis_tlast_i,   // last
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam logic [SEG_W-1:0] SEG_PATTERN [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  result_t digit_q[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic predict_digits(input logic [NUMBER_W-1:0] number);
    int unsigned rest;
    int unsigned digit;
    result_t     beat;
    rest = number;
    for (int pos = 0; pos < MAX_DIGITS; pos++) begin
      digit             = rest % 10;
      rest              = rest / 10;
      beat.position     = POS_W'(pos);
      beat.digit_value  = DIGIT_W'(digit);
      beat.segments     = SEG_PATTERN[digit];
      beat.digit_select = SEG_W'(1) << (7 - pos);
      beat.last         = (rest == 0) || (pos == MAX_DIGITS - 1);
      digit_q.push_back(beat);
      if (beat.last) break;
    end
  endtask

  task automatic report_field(input string field, input int expected, input int actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, field, expected, actual);
      fail_count_o++;
    end
  endtask

  task automatic check_beat();
    result_t want;
    if (digit_q.size() == 0) begin
      $display("%0t: unexpected digit beat, expected none, actual data 0x%0h last %0b",
               $time, m_axis_tdata_i, m_axis_tlast_i);
      fail_count_o++;
    end else begin
      want = digit_q.pop_front();
      report_field("position", want.position, m_axis_tdata_i[2:0]);
      report_field("digit_value", want.digit_value, m_axis_tdata_i[6:3]);
      report_field("segments", want.segments, m_axis_tdata_i[14:7]);
      report_field("digit_select", want.digit_select, m_axis_tdata_i[22:15]);
      report_field("padding", 0, m_axis_tdata_i[23]);
      report_field("last", want.last, m_axis_tlast_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) predict_digits(s_axis_tdata_i);
      if (m_axis_tvalid_i && m_axis_tready_i) check_beat();
    end
    pending_o = digit_q.size();
  end

endmodule

>>> verif/tb_decimal_seven_segment_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal seven-segment scan testbench
// Feeds directed and random numbers through the scan driver under several
// patterns of sender gaps and receiver stalls, including one long receiver
// hold-off that backs the block up. Checking is done by the checker module.
// ----------------------------------------------------------------------------
module tb_decimal_seven_segment_scan
  import dss_pkg::*;
();

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 90;
  localparam int PRESSURE_ITEMS = 24;
  localparam int unsigned POW10 [9] = '{
    1, 10, 100, 1000, 10000, 100000, 1000000, 10000000, 100000000
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [NUMBER_W-1:0]   s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  hold_go = 1'b0;
  logic                  hold_off = 1'b0;
  int                    fail_count;
  int                    pending;
  int                    idle_pct = 0;
  int                    stall_pct = 0;
  int                    cycle_count = 0;

  always #6 clk = ~clk;

  decimal_seven_segment_scan dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  dss_scan_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always @(posedge clk) begin
    m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("decimal_seven_segment_scan verification failed");
      $finish;
    end
  end

  function automatic logic [NUMBER_W-1:0] random_number();
    int unsigned k;
    int unsigned lo;
    int unsigned hi;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        return NUMBER_W'($urandom);
      end
      4, 5, 6, 7: begin
        k  = $urandom_range(1, 8);
        lo = (k == 1) ? 0 : POW10[k-1];
        hi = (POW10[k] - 1 > 16777215) ? 16777215 : POW10[k] - 1;
        return NUMBER_W'($urandom_range(lo, hi));
      end
      8: begin
        return NUMBER_W'($urandom_range(0, 99));
      end
      default: begin
        k = $urandom_range(1, 7);
        return NUMBER_W'(POW10[k] + $urandom_range(0, 2) - 1);
      end
    endcase
  endfunction

  task automatic send_number(input logic [NUMBER_W-1:0] number);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= NUMBER_W'($urandom);
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= number;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic random_phase(input int gap_pct, input int hold_pct, input int items);
    idle_pct  = gap_pct;
    stall_pct = hold_pct;
    for (int i = 0; i < items; i++) send_number(random_number());
  endtask

  initial begin
    logic [NUMBER_W-1:0] directed [$];
    directed = {
      24'd0, 24'd1, 24'd9, 24'd10, 24'd19, 24'd99, 24'd100, 24'd909, 24'd1000,
      24'd99999, 24'd100000, 24'd999999, 24'd1000000, 24'd1234567, 24'd9999999,
      24'd10000000, 24'd10000001, 24'd12345678, 24'd16777215, 24'hAAAAAA,
      24'h555555, 24'd8388608, 24'd9876543, 24'd7654321
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_number(directed[i]);

    random_phase(0, 0, PHASE_ITEMS);
    random_phase(49, 0, PHASE_ITEMS);
    random_phase(0, 49, PHASE_ITEMS);
    random_phase(32, 32, PHASE_ITEMS);

    idle_pct  = 0;
    stall_pct = 0;
    hold_go <= 1'b1;
    for (int i = 0; i < PRESSURE_ITEMS; i++) begin
      send_number(NUMBER_W'($urandom_range(1000000, 16777215)));
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("decimal_seven_segment_scan verification clean");
    end else begin
      $display("decimal_seven_segment_scan verification failed");
    end
    $finish;
  end

endmodule

>>> decimal_seven_segment_scan.f
hw/rtl/dss_pkg.sv
hw/rtl/dss_bcd_stage.sv
hw/rtl/dss_digit_emit.sv
hw/rtl/decimal_seven_segment_scan.sv
verif/dss_scan_checker.sv
verif/tb_decimal_seven_segment_scan.sv
